>>> rtl/assert_macros.svh
// assertion helpers, switched off for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/hvt_pkg.sv
package hvt_pkg;

   localparam int DataWidth     = 32;
   localparam int ElemCount     = 4;
   localparam int ProdWidth     = 2 * DataWidth;
   localparam int PairWidth     = ProdWidth + 1;
   localparam int SumWidth      = ProdWidth + 2;
   localparam int RegCount      = 8;
   localparam int RegSelWidth   = 3;
   localparam int CsrIndexWidth = 4;
   localparam int CsrDataWidth  = 64;

   // register indexes
   localparam logic [RegSelWidth-1:0] RegRow0Cols01 = 3'd0;
   localparam logic [RegSelWidth-1:0] RegRow0Cols23 = 3'd1;
   localparam logic [RegSelWidth-1:0] RegRow1Cols01 = 3'd2;
   localparam logic [RegSelWidth-1:0] RegRow1Cols23 = 3'd3;
   localparam logic [RegSelWidth-1:0] RegRow2Cols01 = 3'd4;
   localparam logic [RegSelWidth-1:0] RegRow2Cols23 = 3'd5;
   localparam logic [RegSelWidth-1:0] RegRow3Cols01 = 3'd6;
   localparam logic [RegSelWidth-1:0] RegRow3Cols23 = 3'd7;

   typedef logic signed [DataWidth-1:0] coord_type;
   typedef coord_type vec4_type [ElemCount];

   // stage advance enables shared by the lanes and the merge stage
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

endpackage

>>> rtl/hvt_lane.sv
module hvt_lane
   import hvt_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  stage_en_type en,
   input  vec4_type     coef,
   input  vec4_type     vtx,
   output coord_type    row_out
);

   logic signed [ProdWidth-1:0] prod_in  [ElemCount];
   logic signed [ProdWidth-1:0] prod_ff  [ElemCount];
   logic signed [PairWidth-1:0] pair_in  [2];
   logic signed [PairWidth-1:0] pair_ff  [2];
   logic signed [SumWidth-1:0]  total;
   logic signed [SumWidth-1:0]  shifted;

   // stage 1: four products
   always_comb begin
      for (int c = 0; c < ElemCount; c++) begin
         prod_in[c] = coef[c] * vtx[c];
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         prod_ff <= prod_in;
      end
   end

   // stage 2: pair sums
   always_comb begin
      pair_in[0] = PairWidth'(prod_ff[0]) + PairWidth'(prod_ff[1]);
      pair_in[1] = PairWidth'(prod_ff[2]) + PairWidth'(prod_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         pair_ff <= pair_in;
      end
   end

   // final add, floor shift, saturation
   always_comb begin
      total   = SumWidth'(pair_ff[0]) + SumWidth'(pair_ff[1]);
      shifted = total >>> FRAC_BITS;
      if (shifted[SumWidth-1:DataWidth-1] == '0 ||
          shifted[SumWidth-1:DataWidth-1] == '1) begin
         row_out = shifted[DataWidth-1:0];
      end else if (shifted[SumWidth-1]) begin
         row_out = {1'b1, {(DataWidth-1){1'b0}}};
      end else begin
         row_out = {1'b0, {(DataWidth-1){1'b1}}};
      end
   end

endmodule

>>> rtl/hvt_merge.sv
module hvt_merge
   import hvt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  stage_en_type en,
   input  logic         valid,
   input  logic         last,
   input  vec4_type     rows,
   output logic         out_valid,
   output vec4_type     out_rows,
   output logic         out_last
);

   logic     valid_ff;
   vec4_type rows_ff;
   logic     last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en.s3) begin
         valid_ff <= valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         rows_ff <= rows;
         last_ff <= last;
      end
   end

   assign out_valid = valid_ff;
   assign out_rows  = rows_ff;
   assign out_last  = last_ff;

endmodule

>>> rtl/homogeneous_vertex_transform.sv
// channel | direction | ports
// req     | in        | req_valid, req_stall, req_x/y/z/w, req_last
// rsp     | out       | rsp_valid, rsp_stall, rsp_x/y/z/w, rsp_last
// csr     | in        | csr_valid, csr_ready, csr_index, csr_wdata
//
// one word per cycle while the output is not stalled; a taken word has its
// products registered at the edge that takes it, then its pair sums, then the
// output register
// the rate is set by the four row lanes, each with four 32x32 multipliers
// reset clears the pipeline valids and loads the identity matrix
// a stalled output holds; words behind it fill the empty stages before
// req_stall rises
`include "assert_macros.svh"

module homogeneous_vertex_transform
   import hvt_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // vertex input
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [31:0]       req_x,
   input  logic signed [31:0]       req_y,
   input  logic signed [31:0]       req_z,
   input  logic signed [31:0]       req_w,
   input  logic                     req_last,
   // transformed vertex
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [31:0]       rsp_x,
   output logic signed [31:0]       rsp_y,
   output logic signed [31:0]       rsp_z,
   output logic signed [31:0]       rsp_w,
   output logic                     rsp_last,
   // matrix registers
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   // 1.0 in the fixed-point format, placed in the low or high coefficient
   localparam logic [CsrDataWidth-1:0] OneLow  = CsrDataWidth'(1) << FRAC_BITS;
   localparam logic [CsrDataWidth-1:0] OneHigh = OneLow << DataWidth;

   logic [CsrDataWidth-1:0] coef_ff [RegCount];
   logic [CsrDataWidth-1:0] coef_in [RegCount];

   stage_en_type en;
   logic         v1_ff, v1_in;
   logic         v2_ff, v2_in;
   logic         last1_ff;
   logic         last2_ff;
   vec4_type     vtx;
   vec4_type     rows;
   vec4_type     out_rows;

   // matrix registers: always ready, writes beyond the list are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      coef_in = coef_ff;
      if (csr_valid && csr_ready &&
          csr_index < CsrIndexWidth'(RegCount)) begin
         coef_in[csr_index[RegSelWidth-1:0]] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[RegRow0Cols01] <= OneLow;
         coef_ff[RegRow0Cols23] <= '0;
         coef_ff[RegRow1Cols01] <= OneHigh;
         coef_ff[RegRow1Cols23] <= '0;
         coef_ff[RegRow2Cols01] <= '0;
         coef_ff[RegRow2Cols23] <= OneLow;
         coef_ff[RegRow3Cols01] <= '0;
         coef_ff[RegRow3Cols23] <= OneHigh;
      end else begin
         coef_ff <= coef_in;
      end
   end

   // pipeline advance: a stage moves when it is empty or the next one moves
   always_comb begin
      en.s3 = !rsp_valid || !rsp_stall;
      en.s2 = !v2_ff || en.s3;
      en.s1 = !v1_ff || en.s2;
   end

   assign req_stall = !en.s1;
   assign v1_in     = en.s1 ? req_valid : v1_ff;
   assign v2_in     = en.s2 ? v1_ff : v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   // last flag travels alongside the lane stages
   always_ff @(posedge clock) begin
      if (en.s1) begin
         last1_ff <= req_last;
      end
      if (en.s2) begin
         last2_ff <= last1_ff;
      end
   end

   assign vtx[0] = req_x;
   assign vtx[1] = req_y;
   assign vtx[2] = req_z;
   assign vtx[3] = req_w;

   // one lane per matrix row
   for (genvar r = 0; r < ElemCount; r++) begin : g_row
      vec4_type coef_row;

      always_comb begin
         coef_row[0] = coef_ff[2*r][DataWidth-1:0];
         coef_row[1] = coef_ff[2*r][CsrDataWidth-1:DataWidth];
         coef_row[2] = coef_ff[2*r+1][DataWidth-1:0];
         coef_row[3] = coef_ff[2*r+1][CsrDataWidth-1:DataWidth];
      end

      hvt_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock   (clock),
         .en      (en),
         .coef    (coef_row),
         .vtx     (vtx),
         .row_out (rows[r])
      );
   end

   // output register gathers the four rows
   hvt_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid     (v2_ff),
      .last      (last2_ff),
      .rows      (rows),
      .out_valid (rsp_valid),
      .out_rows  (out_rows),
      .out_last  (rsp_last)
   );

   assign rsp_x = out_rows[0];
   assign rsp_y = out_rows[1];
   assign rsp_z = out_rows[2];
   assign rsp_w = out_rows[3];

   // a taken word reaches the product stage
   `ASSERT_NEXT(a_accept_fills, clock, reset, req_valid && !req_stall, v1_ff)
   // input only stalls with every stage full and the output blocked
   `ASSERT_IMPLIES(a_stall_full, clock, reset, req_stall, v1_ff && v2_ff && rsp_valid && rsp_stall)
   // a blocked pair-sum stage keeps its word
   `ASSERT_NEXT(a_hold_s2, clock, reset, v2_ff && !en.s3, v2_ff)

endmodule
